// ----- hdl/server_slot_dispatcher_unit_assert.svh -----
// Assertion shorthands used by the dispatcher back end.
`ifndef SERVER_SLOT_DISPATCHER_UNIT_ASSERT_SVH
`define SERVER_SLOT_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/ssd_pkg.sv -----
package ssd_pkg;

  localparam int NUM_SERVERS      = 4;
  localparam int SLOTS_PER_SERVER = 4;
  localparam int NUM_SLOTS        = NUM_SERVERS * SLOTS_PER_SERVER;

  localparam int OP_W   = 3;
  localparam int SRV_W  = 2;
  localparam int SLOT_W = 4;
  localparam int ACT_W  = 3;
  localparam int CNT_W  = 16;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = 1;
  localparam int CQ_CNT_W = 2;

  // Input op codes
  localparam logic [OP_W-1:0] OP_LOCAL    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOTE   = 3'd1;
  localparam logic [OP_W-1:0] OP_PROBE    = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
  localparam logic [OP_W-1:0] OP_BLOCKED  = 3'd4;
  localparam logic [OP_W-1:0] OP_TIMEOUT  = 3'd5;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_TO_SERVER = 3'd0;
  localparam logic [ACT_W-1:0] ACT_QUEUED    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PROBE     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ACK       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QACK      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_NACK      = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UPDATE    = 3'd7;

  // Command classes produced by the front
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NONE    = 3'd0;
  localparam kind_t KIND_JOB     = 3'd1;
  localparam kind_t KIND_PROBE   = 3'd2;
  localparam kind_t KIND_RELEASE = 3'd3;
  localparam kind_t KIND_BLOCKED = 3'd4;

  typedef struct packed {
    kind_t            kind;
    logic             is_local;
    logic             is_timeout;
    logic [SRV_W-1:0] server;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    cmd_t             cmd;
  } cmd_link_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SRV_W-1:0]  target;
    logic [SLOT_W-1:0] slot;
  } res_t;

  // Lowest set bit: isolate it with v & -v, then encode its position
  function automatic logic [SRV_W-1:0] first_set_srv(input logic [NUM_SERVERS-1:0] v);
    logic [NUM_SERVERS-1:0] iso;
    logic [SRV_W-1:0]       idx;
    iso = v & (~v + NUM_SERVERS'(1));
    idx = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      if (iso[i]) idx = idx | SRV_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SLOT_W-1:0] first_set_slot(input logic [NUM_SLOTS-1:0] v);
    logic [NUM_SLOTS-1:0] iso;
    logic [SLOT_W-1:0]    idx;
    iso = v & (~v + NUM_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (iso[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SLOT_W-1:0] first_set_grp(
    input logic [SLOTS_PER_SERVER-1:0] v);
    logic [SLOTS_PER_SERVER-1:0] iso;
    logic [SLOT_W-1:0]           idx;
    iso = v & (~v + SLOTS_PER_SERVER'(1));
    idx = '0;
    for (int i = 0; i < SLOTS_PER_SERVER; i++) begin
      if (iso[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- hdl/server_slot_dispatcher_unit.sv -----
// Job dispatcher over four servers, each with four queue slots.
// Input channel: a word (op, server_index) is taken when push is high and
// full is low. Result channel: the oldest result sits on action,
// target_server, slot_index and the four counters while empty is low; it
// leaves when pop is high. Every accepted word yields exactly one result.
// probe_enabled is written whenever probe_enabled_we is high.
// Flow: an accepted word enters the command queue, then moves into the
// result register (empty falls) when that register is free or being
// popped. Throughput: one word per cycle while results are popped; the
// back end decides a word from the server and slot maps, and a two-entry
// command queue lets the input run ahead.
// When pop is held low the result register holds, the back end waits and
// the command queue fills; full rises once it holds two words.
// Reset (rst, synchronous): every server idle, every slot free, counters
// and probe_enabled zero, both queues empty.
module server_slot_dispatcher_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ssd_pkg::OP_W-1:0]    op,
  input  logic [ssd_pkg::SRV_W-1:0]   server_index,
  output logic                        empty,
  input  logic                        pop,
  output logic [ssd_pkg::ACT_W-1:0]   action,
  output logic [ssd_pkg::SRV_W-1:0]   target_server,
  output logic [ssd_pkg::SLOT_W-1:0]  slot_index,
  output logic [ssd_pkg::CNT_W-1:0]   local_job_count,
  output logic [ssd_pkg::CNT_W-1:0]   remote_job_count,
  output logic [ssd_pkg::CNT_W-1:0]   blocked_count,
  output logic [ssd_pkg::CNT_W-1:0]   timeout_count,
  input  logic                        probe_enabled_we,
  input  logic                        probe_enabled
);

  ssd_pkg::cmd_link_t link;
  logic               link_pop;

  ssd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .op           (op),
    .server_index (server_index),
    .link_out     (link),
    .link_pop     (link_pop)
  );

  ssd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .probe_enabled_we (probe_enabled_we),
    .probe_enabled    (probe_enabled),
    .link_in          (link),
    .link_pop         (link_pop),
    .empty            (empty),
    .pop              (pop),
    .action           (action),
    .target_server    (target_server),
    .slot_index       (slot_index),
    .local_job_count  (local_job_count),
    .remote_job_count (remote_job_count),
    .blocked_count    (blocked_count),
    .timeout_count    (timeout_count)
  );

endmodule

// ----- hdl/ssd_front.sv -----
module ssd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ssd_pkg::OP_W-1:0]    op,
  input  logic [ssd_pkg::SRV_W-1:0]   server_index,
  output ssd_pkg::cmd_link_t          link_out,
  input  logic                        link_pop
);

  ssd_pkg::cmd_t                      cmd_in;
  ssd_pkg::cmd_t                      cq [ssd_pkg::CQ_DEPTH];
  logic [ssd_pkg::CQ_PTR_W-1:0]       wr_ptr;
  logic [ssd_pkg::CQ_PTR_W-1:0]       rd_ptr;
  logic [ssd_pkg::CQ_CNT_W-1:0]       cq_cnt;
  logic [ssd_pkg::CQ_CNT_W-1:0]       cq_cnt_next;
  logic                               wr_go;
  logic                               rd_go;

  // Classify the incoming word
  always_comb begin
    cmd_in.kind       = ssd_pkg::KIND_NONE;
    cmd_in.is_local   = (op == ssd_pkg::OP_LOCAL);
    cmd_in.is_timeout = (op == ssd_pkg::OP_TIMEOUT);
    cmd_in.server     = server_index;
    case (op) inside
      ssd_pkg::OP_LOCAL, ssd_pkg::OP_REMOTE:     cmd_in.kind = ssd_pkg::KIND_JOB;
      ssd_pkg::OP_PROBE:                         cmd_in.kind = ssd_pkg::KIND_PROBE;
      ssd_pkg::OP_COMPLETE, ssd_pkg::OP_TIMEOUT: cmd_in.kind = ssd_pkg::KIND_RELEASE;
      ssd_pkg::OP_BLOCKED:                       cmd_in.kind = ssd_pkg::KIND_BLOCKED;
      default:                                   cmd_in.kind = ssd_pkg::KIND_NONE;
    endcase
  end

  assign full  = (cq_cnt == ssd_pkg::CQ_CNT_W'(ssd_pkg::CQ_DEPTH));
  assign wr_go = push && !full;
  assign rd_go = link_pop && (cq_cnt != '0);

  always_comb begin
    cq_cnt_next = cq_cnt;
    if (wr_go && !rd_go) cq_cnt_next = cq_cnt + ssd_pkg::CQ_CNT_W'(1);
    if (!wr_go && rd_go) cq_cnt_next = cq_cnt - ssd_pkg::CQ_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cq_cnt <= '0;
    end else begin
      cq_cnt <= cq_cnt_next;
      if (wr_go) wr_ptr <= wr_ptr + ssd_pkg::CQ_PTR_W'(1);
      if (rd_go) rd_ptr <= rd_ptr + ssd_pkg::CQ_PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) cq[wr_ptr] <= cmd_in;
  end

  always_comb begin
    link_out.valid = (cq_cnt != '0);
    link_out.cmd   = cq[rd_ptr];
  end

endmodule

// ----- hdl/ssd_back.sv -----
`include "server_slot_dispatcher_unit_assert.svh"

module ssd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        probe_enabled_we,
  input  logic                        probe_enabled,
  input  ssd_pkg::cmd_link_t          link_in,
  output logic                        link_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [ssd_pkg::ACT_W-1:0]   action,
  output logic [ssd_pkg::SRV_W-1:0]   target_server,
  output logic [ssd_pkg::SLOT_W-1:0]  slot_index,
  output logic [ssd_pkg::CNT_W-1:0]   local_job_count,
  output logic [ssd_pkg::CNT_W-1:0]   remote_job_count,
  output logic [ssd_pkg::CNT_W-1:0]   blocked_count,
  output logic [ssd_pkg::CNT_W-1:0]   timeout_count
);

  logic                               probe_en;
  logic [ssd_pkg::NUM_SERVERS-1:0]    server_busy;
  logic [ssd_pkg::NUM_SERVERS-1:0]    server_busy_next;
  logic [ssd_pkg::NUM_SLOTS-1:0]      slot_busy;
  logic [ssd_pkg::NUM_SLOTS-1:0]      slot_busy_next;
  logic [ssd_pkg::CNT_W-1:0]          local_cnt, local_cnt_next;
  logic [ssd_pkg::CNT_W-1:0]          remote_cnt, remote_cnt_next;
  logic [ssd_pkg::CNT_W-1:0]          blocked_cnt, blocked_cnt_next;
  logic [ssd_pkg::CNT_W-1:0]          timeout_cnt, timeout_cnt_next;
  logic                               res_valid;
  ssd_pkg::res_t                      res;
  ssd_pkg::res_t                      res_next;
  logic                               cmd_go;
  ssd_pkg::cmd_t                      cmd;
  logic                               any_idle;
  logic                               any_free;
  logic [ssd_pkg::SRV_W-1:0]          idle_srv;
  logic [ssd_pkg::SLOT_W-1:0]         free_slot;
  logic [ssd_pkg::SLOT_W-1:0]         grp_base;
  logic [ssd_pkg::SLOTS_PER_SERVER-1:0] grp_busy;
  logic [ssd_pkg::SLOT_W-1:0]         grp_slot;

  assign cmd      = link_in.cmd;
  // Advance only when the result register is free or being emptied
  assign cmd_go   = link_in.valid && (!res_valid || pop);
  assign link_pop = cmd_go;

  assign any_idle  = !(&server_busy);
  assign any_free  = !(&slot_busy);
  assign idle_srv  = ssd_pkg::first_set_srv(~server_busy);
  assign free_slot = ssd_pkg::first_set_slot(~slot_busy);
  assign grp_base  = ssd_pkg::SLOT_W'({2'b00, cmd.server} *
                                      ssd_pkg::SLOT_W'(ssd_pkg::SLOTS_PER_SERVER));
  assign grp_busy  = slot_busy[grp_base +: ssd_pkg::SLOTS_PER_SERVER];
  assign grp_slot  = grp_base + ssd_pkg::first_set_grp(grp_busy);

  always_comb begin
    server_busy_next = server_busy;
    slot_busy_next   = slot_busy;
    local_cnt_next   = local_cnt;
    remote_cnt_next  = remote_cnt;
    blocked_cnt_next = blocked_cnt;
    timeout_cnt_next = timeout_cnt;
    res_next.action  = ssd_pkg::ACT_UPDATE;
    res_next.target  = '0;
    res_next.slot    = '0;
    case (cmd.kind)
      ssd_pkg::KIND_JOB: begin
        if (any_idle) begin
          server_busy_next[idle_srv] = 1'b1;
          res_next.action = ssd_pkg::ACT_TO_SERVER;
          res_next.target = idle_srv;
        end else if (cmd.is_local && probe_en) begin
          res_next.action = ssd_pkg::ACT_PROBE;
        end else if (any_free) begin
          slot_busy_next[free_slot] = 1'b1;
          res_next.action = ssd_pkg::ACT_QUEUED;
          res_next.slot   = free_slot;
          res_next.target = ssd_pkg::SRV_W'(free_slot / ssd_pkg::SLOTS_PER_SERVER);
        end else begin
          res_next.action = ssd_pkg::ACT_DROPPED;
        end
        if (res_next.action == ssd_pkg::ACT_TO_SERVER ||
            res_next.action == ssd_pkg::ACT_QUEUED) begin
          if (cmd.is_local) local_cnt_next  = ssd_pkg::sat_inc(local_cnt);
          else              remote_cnt_next = ssd_pkg::sat_inc(remote_cnt);
        end
      end
      ssd_pkg::KIND_PROBE: begin
        if (any_idle)      res_next.action = ssd_pkg::ACT_ACK;
        else if (any_free) res_next.action = ssd_pkg::ACT_QACK;
        else               res_next.action = ssd_pkg::ACT_NACK;
      end
      ssd_pkg::KIND_RELEASE: begin
        if (cmd.is_timeout) timeout_cnt_next = ssd_pkg::sat_inc(timeout_cnt);
        res_next.target = cmd.server;
        if (int'(cmd.server) < ssd_pkg::NUM_SERVERS) begin
          // Free the lowest busy slot of the server, else mark it idle
          if (|grp_busy) begin
            slot_busy_next[grp_slot] = 1'b0;
            res_next.slot = grp_slot;
          end else begin
            server_busy_next[cmd.server] = 1'b0;
          end
        end
      end
      ssd_pkg::KIND_BLOCKED: begin
        blocked_cnt_next = ssd_pkg::sat_inc(blocked_cnt);
        res_next.target  = cmd.server;
      end
      default: begin
        res_next.action = ssd_pkg::ACT_UPDATE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_en    <= 1'b0;
      server_busy <= '0;
      slot_busy   <= '0;
      local_cnt   <= '0;
      remote_cnt  <= '0;
      blocked_cnt <= '0;
      timeout_cnt <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (probe_enabled_we) probe_en <= probe_enabled;
      if (cmd_go) begin
        server_busy <= server_busy_next;
        slot_busy   <= slot_busy_next;
        local_cnt   <= local_cnt_next;
        remote_cnt  <= remote_cnt_next;
        blocked_cnt <= blocked_cnt_next;
        timeout_cnt <= timeout_cnt_next;
        res_valid   <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_go) res <= res_next;
  end

  assign empty            = !res_valid;
  assign action           = res.action;
  assign target_server    = res.target;
  assign slot_index       = res.slot;
  assign local_job_count  = local_cnt;
  assign remote_job_count = remote_cnt;
  assign blocked_count    = blocked_cnt;
  assign timeout_count    = timeout_cnt;

  `SSD_ASSERT_NEXT(a_server_taken, clk, rst, cmd_go && res_next.action == ssd_pkg::ACT_TO_SERVER, server_busy[target_server])
  `SSD_ASSERT_IMP(a_queue_only_when_busy, clk, rst, cmd_go && res_next.action == ssd_pkg::ACT_QUEUED, &server_busy)
  `SSD_ASSERT_IMP(a_local_cnt_mono, clk, rst, !$past(rst), local_cnt >= $past(local_cnt))
  `SSD_ASSERT_IMP(a_timeout_cnt_mono, clk, rst, !$past(rst), timeout_cnt >= $past(timeout_cnt))

endmodule
